/* rtl/core/interp_cosine_table_lookup_unit_assert.svh */
// Assertion macros shared by the RTL of the interpolated cosine lookup unit.
`ifndef INTERP_COSINE_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define INTERP_COSINE_TABLE_LOOKUP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICTL_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICTL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ictl_pkg.sv */
package ictl_pkg;

    localparam int TABLE_LOG2_SIZE_DEF    = 9;
    localparam int TURN_FRACTION_BITS_DEF = 32;
    localparam int ANGLE_W                = 32;
    localparam int VALUE_W                = 32;
    localparam int PRODUCT_SHIFT          = 26;
    localparam int SERIES_TERMS           = 8;

    localparam logic signed [ANGLE_W:0] HALF_PI_Q24    = 33'sd26353589;
    localparam logic [ANGLE_W-1:0]      INV_TWO_PI_Q26 = 32'd2734261102;
    localparam logic [63:0]             TWO_PI_Q32     = 64'd26986075409;
    localparam logic [ANGLE_W-1:0]      MAG_MAX        = 32'd2173837237;
    localparam logic signed [VALUE_W-1:0] Q30_ONE      = 32'sd1073741824;

    // Divisors (n+1)(n+2) of the Taylor series, cosine row first, sine row second.
    localparam logic [8:0] SERIES_DIV [2][SERIES_TERMS] = '{
        '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240},
        '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272}
    };

    // Cosine or sine of an angle up to pi/4 given in Q0.32, result in Q0.32.
    function automatic logic [63:0] octant_series(input logic [63:0] th, input logic odd);
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic        sub;
        th2  = (th * th) >> 32;
        term = odd ? th : 64'h0000_0001_0000_0000;
        sum  = term;
        sub  = 1'b1;
        for (int k = 0; k < SERIES_TERMS; k++)
        begin
            term = ((term * th2) >> 32) / 64'(SERIES_DIV[odd][k]);
            sum  = sub ? (sum - term) : (sum + term);
            sub  = !sub;
        end
        return sum;
    endfunction

    function automatic logic signed [VALUE_W-1:0] to_q30(input logic [63:0] q32);
        logic [63:0] rounded;
        rounded = (q32 + 64'd2) >> 2;
        return rounded[VALUE_W-1:0];
    endfunction

    // Table entry i, cos(2*pi*i / 2^log2size) in Q1.30, built from octant symmetry.
    function automatic logic signed [VALUE_W-1:0] table_sample(input int unsigned i,
                                                               input int log2size);
        int unsigned             quarter;
        int unsigned             p;
        int unsigned             q;
        int unsigned             r;
        logic [63:0]             th;
        logic signed [VALUE_W-1:0] c;
        logic signed [VALUE_W-1:0] s;
        logic signed [VALUE_W-1:0] res;
        quarter = 1 << (log2size - 2);
        p       = i & ((1 << log2size) - 1);
        q       = (p >> (log2size - 2)) & 3;
        r       = p & (quarter - 1);
        if (2 * r <= quarter)
        begin
            th = (64'(r) * TWO_PI_Q32) >> log2size;
            c  = to_q30(octant_series(th, 1'b0));
            s  = to_q30(octant_series(th, 1'b1));
        end
        else
        begin
            th = (64'(quarter - r) * TWO_PI_Q32) >> log2size;
            c  = to_q30(octant_series(th, 1'b1));
            s  = to_q30(octant_series(th, 1'b0));
        end
        case (q)
            0:       res = c;
            1:       res = -s;
            2:       res = -c;
            default: res = s;
        endcase
        return res;
    endfunction

endpackage

/* rtl/core/ictl_angle_if.sv */
interface ictl_angle_if
    import ictl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;
    logic                      req_type;

    modport source (output valid, output angle, output req_type, input ready);
    modport sink (input valid, input angle, input req_type, output ready);
endinterface

/* rtl/core/ictl_value_if.sv */
interface ictl_value_if
    import ictl_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

/* rtl/core/ictl_table_rom.sv */
module ictl_table_rom
    import ictl_pkg::*;
#(
    parameter int TABLE_LOG2_SIZE = TABLE_LOG2_SIZE_DEF
)(
    input  logic                       clk,
    input  logic                       en,
    input  logic [TABLE_LOG2_SIZE-1:0] idx,
    output logic signed [VALUE_W-1:0]  left,
    output logic signed [VALUE_W-1:0]  right
);

    localparam int HALF_DEPTH = 2 ** (TABLE_LOG2_SIZE - 1);

    // Even entries in one bank and odd entries in the other, so an entry and its
    // right neighbor are always read from different banks.
    logic signed [VALUE_W-1:0]     even_rom [HALF_DEPTH+1];
    logic signed [VALUE_W-1:0]     odd_rom  [HALF_DEPTH];
    logic [TABLE_LOG2_SIZE-1:0]    even_addr;
    logic [TABLE_LOG2_SIZE-2:0]    odd_addr;
    logic signed [VALUE_W-1:0]     even_rd_reg;
    logic signed [VALUE_W-1:0]     odd_rd_reg;
    logic                          sel_odd_reg;

    for (genvar g = 0; g <= HALF_DEPTH; g++)
    begin : g_even
        assign even_rom[g] = table_sample(32'(2 * g), TABLE_LOG2_SIZE);
    end

    for (genvar g = 0; g < HALF_DEPTH; g++)
    begin : g_odd
        assign odd_rom[g] = table_sample(32'(2 * g + 1), TABLE_LOG2_SIZE);
    end

    assign odd_addr  = idx[TABLE_LOG2_SIZE-1:1];
    assign even_addr = {1'b0, odd_addr} + TABLE_LOG2_SIZE'(idx[0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            even_rd_reg <= even_rom[even_addr];
            odd_rd_reg  <= odd_rom[odd_addr];
            sel_odd_reg <= idx[0];
        end
    end

    assign left  = sel_odd_reg ? odd_rd_reg : even_rd_reg;
    assign right = sel_odd_reg ? even_rd_reg : odd_rd_reg;

endmodule

/* rtl/core/interp_cosine_table_lookup_unit.sv */
// Interpolated cosine and sine lookup.
// The angle_ch channel carries one transaction per angle: a signed Q8.24 angle in
// radians and req_type, 0 for cosine and 1 for sine. The value_ch channel returns
// one transaction per angle with the Q1.30 result, in the order the angles came in.
// The datapath is a seven-stage pipeline: offset, magnitude, scaling to a fraction
// of a turn, dual-bank table read, difference, interpolation product, rounding and
// sum. An angle passes a_reg, mag_reg, turn_reg, the ROM read registers, diff4_reg,
// prod5_reg and value_reg, which drives value_ch. Unless value_ch stalls, one angle is
// accepted per clock; the scaling and interpolation multipliers each fill a full stage.
// The cosine table is a constant ROM split into even and odd banks, so no fill or
// clearing pass follows reset: the block takes angles from the first cycle after
// rst_n is released. Reset empties the pipeline and drops any pending results.
// When value_ch stalls, each stage holds its contents; empty stages still accept
// data, so angle_ch keeps taking transactions until every stage is occupied.
`include "interp_cosine_table_lookup_unit_assert.svh"

module interp_cosine_table_lookup_unit
    import ictl_pkg::*;
#(
    parameter int TABLE_LOG2_SIZE    = TABLE_LOG2_SIZE_DEF,
    parameter int TURN_FRACTION_BITS = TURN_FRACTION_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    ictl_angle_if.sink   angle_ch,
    ictl_value_if.source value_ch
);

    localparam int INTERP_BITS = TURN_FRACTION_BITS - TABLE_LOG2_SIZE;
    localparam int DIFF_W      = VALUE_W + 1;
    localparam int PROD_W      = DIFF_W + INTERP_BITS + 1;
    localparam int NUM_STAGES  = 7;
    localparam int T32_MSB     = PRODUCT_SHIFT + ANGLE_W - 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (INTERP_BITS - 1);

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    logic signed [ANGLE_W:0]        a_reg;
    logic signed [ANGLE_W:0]        a_next;
    logic [ANGLE_W-1:0]             mag_reg;
    logic [ANGLE_W-1:0]             mag_next;
    logic [2*ANGLE_W-1:0]           scale_prod;
    logic [TURN_FRACTION_BITS-1:0]  turn_reg;
    logic [INTERP_BITS-1:0]         fr3_reg;
    logic signed [VALUE_W-1:0]      rom_left;
    logic signed [VALUE_W-1:0]      rom_right;
    logic signed [VALUE_W-1:0]      left4_reg;
    logic signed [DIFF_W-1:0]       diff4_reg;
    logic signed [DIFF_W-1:0]       diff4_next;
    logic [INTERP_BITS-1:0]         fr4_reg;
    logic signed [PROD_W-1:0]       diff_ext;
    logic signed [PROD_W-1:0]       fr_ext;
    logic signed [VALUE_W-1:0]      left5_reg;
    logic signed [PROD_W-1:0]       prod5_reg;
    logic signed [PROD_W-1:0]       prod5_next;
    logic signed [PROD_W-1:0]       rounded;
    logic signed [PROD_W-1:0]       interp;
    logic signed [DIFF_W-1:0]       sum;
    logic signed [VALUE_W-1:0]      value_reg;

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || value_ch.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        vld_next[0] = stage_en[0] ? angle_ch.valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = stage_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign angle_ch.ready = stage_en[0];

    assign a_next = {angle_ch.angle[ANGLE_W-1], angle_ch.angle}
                    - (angle_ch.req_type ? HALF_PI_Q24 : '0);
    assign mag_next   = a_reg[ANGLE_W] ? ANGLE_W'(-a_reg) : a_reg[ANGLE_W-1:0];
    assign scale_prod = {{ANGLE_W{1'b0}}, mag_reg} * {{ANGLE_W{1'b0}}, INV_TWO_PI_Q26};
    assign diff4_next = {rom_right[VALUE_W-1], rom_right} - {rom_left[VALUE_W-1], rom_left};
    assign diff_ext   = PROD_W'(diff4_reg);
    assign fr_ext     = PROD_W'({1'b0, fr4_reg});
    assign prod5_next = diff_ext * fr_ext;
    assign rounded    = prod5_reg + ROUND_HALF;
    assign interp     = rounded >>> INTERP_BITS;
    assign sum        = {left5_reg[VALUE_W-1], left5_reg} + interp[DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            a_reg <= a_next;
        end
        if (stage_en[1])
        begin
            mag_reg <= mag_next;
        end
        if (stage_en[2])
        begin
            turn_reg <= scale_prod[T32_MSB -: TURN_FRACTION_BITS];
        end
        if (stage_en[3])
        begin
            fr3_reg <= turn_reg[INTERP_BITS-1:0];
        end
        if (stage_en[4])
        begin
            left4_reg <= rom_left;
            diff4_reg <= diff4_next;
            fr4_reg   <= fr3_reg;
        end
        if (stage_en[5])
        begin
            left5_reg <= left4_reg;
            prod5_reg <= prod5_next;
        end
        if (stage_en[6])
        begin
            value_reg <= sum[VALUE_W-1:0];
        end
    end

    ictl_table_rom #(
        .TABLE_LOG2_SIZE (TABLE_LOG2_SIZE)
    ) u_table_rom (
        .clk   (clk),
        .en    (stage_en[3]),
        .idx   (turn_reg[TURN_FRACTION_BITS-1 -: TABLE_LOG2_SIZE]),
        .left  (rom_left),
        .right (rom_right)
    );

    assign value_ch.valid = vld_reg[NUM_STAGES-1];
    assign value_ch.value = value_reg;

    `ICTL_ASSERT_NEXT(a_accept_fills_first, angle_ch.valid && angle_ch.ready, vld_reg[0], "accepted angle did not enter the pipeline")
    `ICTL_ASSERT_IMPLY(a_busy_only_when_full, !angle_ch.ready, vld_reg[0], "input stalled while the first stage is empty")
    `ICTL_ASSERT_IMPLY(a_mag_range, vld_reg[1], mag_reg <= MAG_MAX, "angle magnitude out of range")
    `ICTL_ASSERT_IMPLY(a_value_range, value_ch.valid, (value_ch.value <= Q30_ONE) && (value_ch.value >= -Q30_ONE), "result outside unit range")

endmodule

/* bench/interp_cosine_table_lookup_unit_tb.sv */
module interp_cosine_table_lookup_unit_tb;
    import ictl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_LOG2    = TABLE_LOG2_SIZE_DEF;
    localparam int FRAC_BITS   = TURN_FRACTION_BITS_DEF;
    localparam int INTERP_BITS = FRAC_BITS - TBL_LOG2;
    localparam int TBL_ENTRIES = 1 << TBL_LOG2;
    localparam int TAYLOR_TERMS = 8;

    localparam longint      QUARTER_TURN_Q24 = 64'sd26353589;
    localparam logic [63:0] RECIP_TWO_PI_Q26 = 64'd2734261102;
    localparam logic [63:0] FULL_TURN_Q32    = 64'd26986075409;
    localparam logic [31:0] TWO_PI_Q24       = 32'd105414357;

    localparam bit REQ_COS = 1'b0;
    localparam bit REQ_SIN = 1'b1;

    logic clk;
    logic rst_n;

    ictl_angle_if angle_ch ();
    ictl_value_if value_ch ();

    interp_cosine_table_lookup_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle_ch (angle_ch.sink),
        .value_ch (value_ch.source)
    );

    logic signed [VALUE_W-1:0] cos_table_q30 [TBL_ENTRIES+1];
    logic signed [VALUE_W-1:0] expected_values [$];

    int errors;
    int cos_sent;
    int sin_sent;
    int values_checked;
    bit idle_on;
    int hold_cycles;

    // Taylor series for cos or sin of an angle up to a quarter of pi, Q0.32 in and out.
    function automatic logic [63:0] taylor_q32(input logic [63:0] th, input bit odd);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] n;
        bit          sub;
        sq   = (th * th) >> 32;
        term = odd ? th : 64'h0000_0001_0000_0000;
        acc  = term;
        n    = odd ? 64'd1 : 64'd0;
        sub  = 1'b1;
        for (int k = 0; k < TAYLOR_TERMS; k++)
        begin
            term = ((term * sq) >> 32) / ((n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
            acc  = sub ? (acc - term) : (acc + term);
            sub  = !sub;
        end
        return acc;
    endfunction

    function automatic logic signed [VALUE_W-1:0] round_q30(input logic [63:0] q32);
        logic [63:0] rounded;
        rounded = (q32 + 64'd2) >> 2;
        return rounded[VALUE_W-1:0];
    endfunction

    function automatic void build_cos_table();
        int unsigned quarter;
        int unsigned p;
        int unsigned q;
        int unsigned r;
        logic [63:0] th;
        logic signed [VALUE_W-1:0] c;
        logic signed [VALUE_W-1:0] s;
        quarter = TBL_ENTRIES / 4;
        for (int unsigned i = 0; i <= TBL_ENTRIES; i++)
        begin
            p = i & (TBL_ENTRIES - 1);
            q = (p >> (TBL_LOG2 - 2)) & 3;
            r = p & (quarter - 1);
            if (2 * r <= quarter)
            begin
                th = (64'(r) * FULL_TURN_Q32) >> TBL_LOG2;
                c  = round_q30(taylor_q32(th, 1'b0));
                s  = round_q30(taylor_q32(th, 1'b1));
            end
            else
            begin
                th = (64'(quarter - r) * FULL_TURN_Q32) >> TBL_LOG2;
                c  = round_q30(taylor_q32(th, 1'b1));
                s  = round_q30(taylor_q32(th, 1'b0));
            end
            case (q)
                0:       cos_table_q30[i] = c;
                1:       cos_table_q30[i] = -s;
                2:       cos_table_q30[i] = -c;
                default: cos_table_q30[i] = s;
            endcase
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] predict_trig(
        input logic signed [ANGLE_W-1:0] ang, input bit req);
        longint      a;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [31:0] t32;
        logic [31:0] turn;
        int unsigned idx;
        longint      fr;
        longint      lo;
        longint      hi;
        longint      interp;
        longint      res;
        a = longint'(ang);
        if (req == REQ_SIN)
            a = a - QUARTER_TURN_Q24;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = (mag * RECIP_TWO_PI_Q26) >> 26;
        t32  = prod[31:0];
        turn = t32 >> (32 - FRAC_BITS);
        idx  = (turn >> INTERP_BITS) & (TBL_ENTRIES - 1);
        fr   = longint'(turn & ((64'd1 << INTERP_BITS) - 1));
        lo   = longint'(cos_table_q30[idx]);
        hi   = longint'(cos_table_q30[idx+1]);
        interp = ((hi - lo) * fr + (64'sd1 <<< (INTERP_BITS - 1))) >>> INTERP_BITS;
        res  = lo + interp;
        return res[VALUE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] ang;
        case ($urandom_range(0, 3))
            0: ang = $urandom();
            1: ang = $urandom_range(0, 2 * TWO_PI_Q24) - TWO_PI_Q24;
            2: ang = 32'h7FFF_FFFF - $urandom_range(0, 4095);
            default: ang = 32'h8000_0000 + $urandom_range(0, 4095);
        endcase
        return ang;
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_angle(input logic [ANGLE_W-1:0] ang, input bit req);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            angle_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        angle_ch.valid    <= 1'b1;
        angle_ch.angle    <= ang;
        angle_ch.req_type <= req;
        do
            @(posedge clk);
        while (!angle_ch.ready);
        expected_values.push_back(predict_trig(ang, req));
        if (req == REQ_SIN)
            sin_sent++;
        else
            cos_sent++;
    endtask

    task automatic test_directed_extremes();
        logic [ANGLE_W-1:0] corners [5];
        corners = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                    32'h0000_0001};
        foreach (corners[i])
        begin
            send_angle(corners[i], REQ_COS);
            send_angle(corners[i], REQ_SIN);
        end
    endtask

    task automatic test_directed_quadrants();
        send_angle(32'(QUARTER_TURN_Q24), REQ_COS);
        send_angle(32'(QUARTER_TURN_Q24), REQ_SIN);
        send_angle(-32'(QUARTER_TURN_Q24), REQ_SIN);
        send_angle(32'd52707179, REQ_COS);
        send_angle(32'd52707179, REQ_SIN);
        send_angle(TWO_PI_Q24 - 32'd7, REQ_COS);
        send_angle(32'h5555_5555, REQ_SIN);
        send_angle(32'hAAAA_AAAA, REQ_COS);
    endtask

    task automatic test_random_mixed(input int count);
        for (int k = 0; k < count; k++)
        begin
            idle_on = ((k / 100) % 3) != 2;
            send_angle(random_angle(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_output_stall();
        idle_on     = 1'b0;
        hold_cycles = 80;
        for (int k = 0; k < 40; k++)
            send_angle(random_angle(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_streaming(input int count);
        idle_on = 1'b0;
        for (int k = 0; k < count; k++)
            send_angle(random_angle(), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        value_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                value_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                value_ch.ready <= 1'b1;
            end
            else if (rst_n && idle_on && $urandom_range(0, 7) == 0)
            begin
                value_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                value_ch.ready <= 1'b1;
            end
            else
                value_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] want;
        forever
        begin
            @(posedge clk);
            if (rst_n && value_ch.valid && value_ch.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("value: unexpected transaction %0d", value_ch.value);
                    errors++;
                end
                else
                begin
                    want = expected_values.pop_front();
                    values_checked++;
                    if (value_ch.value !== want)
                    begin
                        $error("value: expected %0d, got %0d", want, value_ch.value);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL interp_cosine_table_lookup_unit");
        $finish;
    end

    initial
    begin
        errors            = 0;
        cos_sent          = 0;
        sin_sent          = 0;
        values_checked    = 0;
        idle_on           = 1'b0;
        hold_cycles       = 0;
        rst_n             = 1'b0;
        angle_ch.valid    = 1'b0;
        angle_ch.angle    = '0;
        angle_ch.req_type = 1'b0;
        build_cos_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idle_on = 1'b1;
        test_directed_extremes();
        test_directed_quadrants();
        test_random_mixed(500);
        test_output_stall();
        idle_on = 1'b1;
        test_random_mixed(60);
        test_random_streaming(400);
        angle_ch.valid <= 1'b0;

        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d cosine and %0d sine angle transactions, checked %0d values,",
                 cos_sent, sin_sent, values_checked);
        $display("with random idling on both sides and one long output stall.");
        if (errors == 0)
            $display("PASS interp_cosine_table_lookup_unit");
        else
            $display("FAIL interp_cosine_table_lookup_unit");
        $finish;
    end

endmodule
